[hdl/rtem_pkg.sv]
`timescale 1ns / 1ps

package rtem_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int DEST_W  = 32;
  localparam int MAC_W   = 48;
  localparam int IFACE_W = 8;
  localparam int HOPS_W  = 8;
  localparam int STAMP_W = 48;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_EMIT
  } state_t;

  // one table row as stored in the RAM
  typedef struct packed {
    logic [DEST_W-1:0]  dest;
    logic [MAC_W-1:0]   next_hop;
    logic [IFACE_W-1:0] iface;
    logic [HOPS_W-1:0]  hops;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               found;
    status_t            status;
    logic [MAC_W-1:0]   next_hop;
    logic [IFACE_W-1:0] iface;
    logic [HOPS_W-1:0]  hops;
    logic [STAMP_W-1:0] stamp;
  } result_t;

endpackage

[hdl/rtem_if.sv]
`timescale 1ns / 1ps

interface rtem_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] dest_addr;
  logic [47:0] next_hop_mac;
  logic [7:0]  iface_index;
  logic [7:0]  hop_count;
  logic [47:0] stamp_ms;

  modport source (
    output valid, operation, dest_addr, next_hop_mac, iface_index, hop_count, stamp_ms,
    input  ready
  );
  modport sink (
    input  valid, operation, dest_addr, next_hop_mac, iface_index, hop_count, stamp_ms,
    output ready
  );
endinterface

interface rtem_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [1:0]  status;
  logic [47:0] found_next_hop;
  logic [7:0]  found_iface;
  logic [7:0]  found_hops;
  logic [47:0] found_stamp;

  modport source (
    output valid, found, status, found_next_hop, found_iface, found_hops, found_stamp,
    input  ready
  );
  modport sink (
    input  valid, found, status, found_next_hop, found_iface, found_hops, found_stamp,
    output ready
  );
endinterface

[hdl/rtem_ram.sv]
`timescale 1ns / 1ps

module rtem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/route_table_exact_match_core.sv]
`timescale 1ns / 1ps

// Channel  Dir  Handshake        Payload
// in_ch    in   valid/ready      operation, dest_addr, next_hop_mac, iface_index,
//                                hop_count, stamp_ms
// out_ch   out  valid/ready      found, status, found_next_hop, found_iface,
//                                found_hops, found_stamp
//
// One transaction in flight at a time; in_ch.ready is high only while idle.
// Insert, unused codes, and lookup or delete on an empty table go straight from
// acceptance to the emit step. Lookup: one RAM read per cycle from slot 0 until
// a hit or the last held row. Delete: scan as lookup, then one read/write per cycle
// to shift later rows down, through the single table RAM port pair.
// Synchronous active-low reset empties the table at once; no clearing pass.
// A result waiting on out_ch.ready holds the sequencer in its emit step.
module route_table_exact_match_core #(
  parameter int TABLE_DEPTH = rtem_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rtem_in_if.sink    in_ch,
  rtem_out_if.source out_ch
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  rtem_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     rp_r, rp_nxt;
  logic [AW-1:0]     pa_r, pa_nxt;
  logic              pv_r, pv_nxt;
  logic [31:0]       key_r, key_nxt;
  rtem_pkg::op_t     op_r, op_nxt;
  rtem_pkg::result_t res_r, res_nxt;
  rtem_pkg::result_t out_r;
  logic              out_valid_r;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  rtem_pkg::entry_t  mem_wdata;
  rtem_pkg::entry_t  mem_rdata;

  logic              in_acc;
  logic              issue;
  logic              hit;
  logic              emit;

  rtem_ram #(
    .WIDTH (rtem_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rp_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (state_r == rtem_pkg::S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign issue       = (rp_r < cnt_r);
  assign hit         = pv_r && (mem_rdata.dest == key_r);
  assign emit        = (state_r == rtem_pkg::S_EMIT) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rp_nxt    = rp_r;
    pa_nxt    = pa_r;
    pv_nxt    = pv_r;
    key_nxt   = key_r;
    op_nxt    = op_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = {in_ch.dest_addr, in_ch.next_hop_mac, in_ch.iface_index,
                 in_ch.hop_count, in_ch.stamp_ms};

    case (state_r)
      rtem_pkg::S_IDLE: begin
        if (in_acc) begin
          key_nxt = in_ch.dest_addr;
          op_nxt  = rtem_pkg::op_t'(in_ch.operation);
          res_nxt = '0;
          rp_nxt  = '0;
          pv_nxt  = 1'b0;
          state_nxt = rtem_pkg::S_EMIT;
          case (rtem_pkg::op_t'(in_ch.operation))
            rtem_pkg::OP_INSERT: begin
              if (cnt_r == CW'(TABLE_DEPTH)) begin
                res_nxt.status = rtem_pkg::ST_FULL;
              end else begin
                mem_we  = 1'b1;
                cnt_nxt = CW'(cnt_r + 1'b1);
              end
            end
            rtem_pkg::OP_LOOKUP, rtem_pkg::OP_DELETE: begin
              if (cnt_r == '0) begin
                res_nxt.status = rtem_pkg::ST_NOT_FOUND;
              end else begin
                state_nxt = rtem_pkg::S_SCAN;
              end
            end
            default: begin
              res_nxt.status = rtem_pkg::ST_OK;
            end
          endcase
        end
      end

      rtem_pkg::S_SCAN: begin
        if (hit) begin
          res_nxt.found    = 1'b1;
          res_nxt.status   = rtem_pkg::ST_OK;
          res_nxt.next_hop = mem_rdata.next_hop;
          res_nxt.iface    = mem_rdata.iface;
          res_nxt.hops     = mem_rdata.hops;
          res_nxt.stamp    = mem_rdata.stamp;
          pv_nxt           = 1'b0;
          if (op_r == rtem_pkg::OP_DELETE) begin
            rp_nxt    = CW'(CW'(pa_r) + 1'b1);
            state_nxt = rtem_pkg::S_SHIFT;
          end else begin
            state_nxt = rtem_pkg::S_EMIT;
          end
        end else if (issue) begin
          pv_nxt = 1'b1;
          pa_nxt = rp_r[AW-1:0];
          rp_nxt = CW'(rp_r + 1'b1);
        end else begin
          res_nxt.status = rtem_pkg::ST_NOT_FOUND;
          pv_nxt         = 1'b0;
          state_nxt      = rtem_pkg::S_EMIT;
        end
      end

      rtem_pkg::S_SHIFT: begin
        // row read last cycle moves down one slot
        if (pv_r) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(pa_r - 1'b1);
          mem_wdata = mem_rdata;
        end
        if (issue) begin
          pv_nxt = 1'b1;
          pa_nxt = rp_r[AW-1:0];
          rp_nxt = CW'(rp_r + 1'b1);
        end else begin
          pv_nxt = 1'b0;
          if (!pv_r) begin
            cnt_nxt   = CW'(cnt_r - 1'b1);
            state_nxt = rtem_pkg::S_EMIT;
          end
        end
      end

      rtem_pkg::S_EMIT: begin
        if (emit) begin
          state_nxt = rtem_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rtem_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtem_pkg::S_IDLE;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rp_r  <= rp_nxt;
    pa_r  <= pa_nxt;
    key_r <= key_nxt;
    op_r  <= op_nxt;
    res_r <= res_nxt;
    if (emit) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_r.found;
  assign out_ch.status         = out_r.status;
  assign out_ch.found_next_hop = out_r.next_hop;
  assign out_ch.found_iface    = out_r.iface;
  assign out_ch.found_hops     = out_r.hops;
  assign out_ch.found_stamp    = out_r.stamp;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.operation == rtem_pkg::OP_INSERT && cnt_r != CW'(TABLE_DEPTH))
    |=> (cnt_r == CW'($past(cnt_r) + 1'b1)))
    else $error("insert did not advance entry count");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rtem_pkg::S_SHIFT && mem_we) |-> (CW'(mem_waddr) < cnt_r))
    else $error("shift write outside occupied rows");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (state_r == rtem_pkg::S_IDLE && out_valid_r))
    else $error("result load did not return sequencer to idle");
`endif

endmodule
